[design/tlbpt_pkg.sv]
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared types and constants for the TLB and page table translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  localparam int ADDR_W      = 16;
  localparam int OFFSET_W    = 8;
  localparam int PAGE_IN_W   = 8;
  localparam int FRAME_OUT_W = 7;
  localparam int PA_W        = 15;
  localparam int PAGE_OUT_W  = 8;
  localparam int PAGE_TAB_N  = 256;

  typedef enum logic [1:0] {
    OUT_TLB_HIT = 2'd0,
    OUT_PT_HIT  = 2'd1,
    OUT_FAULT   = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_FAULT
  } state_t;

  typedef struct packed {
    logic insert;
    logic drop;
  } tlb_cmd_t;

endpackage

[design/tlbpt_page_table.sv]
// ----------------------------------------------------------------------------
// tlbpt_page_table
// Page table: frame numbers in a synchronous memory with two registered read
// ports, present bits in flip-flops cleared at reset.
// ----------------------------------------------------------------------------
module tlbpt_page_table import tlbpt_pkg::*; #(
  parameter int PAGE_COUNT  = 256,
  parameter int FRAME_COUNT = 128,
  localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1,
  localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [PW-1:0] rd_addr_a,
  input  logic [PW-1:0] rd_addr_b,
  output logic [FW-1:0] rd_frame_a,
  output logic          rd_present_a,
  output logic [FW-1:0] rd_frame_b,
  output logic          rd_present_b,
  input  logic          wr_en,
  input  logic [PW-1:0] wr_addr,
  input  logic [FW-1:0] wr_frame,
  input  logic          clr_en,
  input  logic [PW-1:0] clr_addr
);

  logic [FW-1:0]         frames [PAGE_COUNT];
  logic [PAGE_COUNT-1:0] present;
  logic [PAGE_COUNT-1:0] present_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frames[wr_addr] <= wr_frame;
    end
    rd_frame_a <= frames[rd_addr_a];
    rd_frame_b <= frames[rd_addr_b];
  end

  // A clear and a set in the same transfer: the set wins, as the new page
  // is installed after the victim is removed.
  always_comb begin
    present_next = present;
    if (clr_en) begin
      present_next[clr_addr] = 1'b0;
    end
    if (wr_en) begin
      present_next[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present      <= '0;
      rd_present_a <= 1'b0;
      rd_present_b <= 1'b0;
    end else begin
      present      <= present_next;
      rd_present_a <= present[rd_addr_a];
      rd_present_b <= present[rd_addr_b];
    end
  end

endmodule

[design/tlbpt_frame_owner.sv]
// ----------------------------------------------------------------------------
// tlbpt_frame_owner
// Reverse map from physical frame to the page that holds it, in a
// synchronous memory with one registered read port.
// ----------------------------------------------------------------------------
module tlbpt_frame_owner import tlbpt_pkg::*; #(
  parameter int PAGE_COUNT  = 256,
  parameter int FRAME_COUNT = 128,
  localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1,
  localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
  input  logic          clk,
  input  logic [FW-1:0] rd_addr,
  output logic [PW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [FW-1:0] wr_addr,
  input  logic [PW-1:0] wr_data
);

  logic [PW-1:0] owners [FRAME_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      owners[wr_addr] <= wr_data;
    end
    rd_data <= owners[rd_addr];
  end

endmodule

[design/tlbpt_tlb.sv]
// ----------------------------------------------------------------------------
// tlbpt_tlb
// Fully associative TLB with round-robin fill and invalidation by frame.
// ----------------------------------------------------------------------------
module tlbpt_tlb import tlbpt_pkg::*; #(
  parameter int TLB_DEPTH   = 16,
  parameter int PAGE_COUNT  = 256,
  parameter int FRAME_COUNT = 128,
  localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1,
  localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1,
  localparam int TW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [PW-1:0] lookup_page,
  output logic          hit,
  output logic [FW-1:0] hit_frame,
  input  tlb_cmd_t      cmd,
  input  logic [PW-1:0] upd_page,
  input  logic [FW-1:0] upd_frame
);

  logic [TLB_DEPTH-1:0] valid;
  logic [TLB_DEPTH-1:0] valid_next;
  logic [PW-1:0]        pages  [TLB_DEPTH];
  logic [FW-1:0]        frames [TLB_DEPTH];
  logic [TW-1:0]        next_slot;

  // Lowest-numbered matching slot wins.
  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
      if (valid[i] && pages[i] == lookup_page) begin
        hit       = 1'b1;
        hit_frame = frames[i];
      end
    end
  end

  // Entries for a reused frame are dropped first; the new entry then lands
  // in the next slot, even if that slot was one of those dropped.
  always_comb begin
    valid_next = valid;
    if (cmd.drop) begin
      for (int i = 0; i < TLB_DEPTH; i++) begin
        if (frames[i] == upd_frame) begin
          valid_next[i] = 1'b0;
        end
      end
    end
    if (cmd.insert) begin
      valid_next[next_slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      next_slot <= '0;
    end else begin
      valid <= valid_next;
      if (cmd.insert) begin
        if (next_slot == TW'(TLB_DEPTH - 1)) begin
          next_slot <= '0;
        end else begin
          next_slot <= next_slot + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      pages[next_slot]  <= upd_page;
      frames[next_slot] <= upd_frame;
    end
  end

endmodule

[design/tlb_page_table_translator.sv]
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Demand-paging address translator with a TLB and FIFO frame replacement.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, logical_address) takes one 16-bit
// logical address per transfer: page in bits 15..8, offset in bits 7..0.
// The output channel (out_valid, out_stall and the result fields) gives one
// result per address: physical address, frame, outcome and any evicted page.
// Timing: a transfer is taken in the idle state; the page table and the frame
// owner memories are read on that edge and their registered reads set the
// pace. A TLB hit or a page table hit is written to the output register from
// the look state; a page fault needs a further page table read for the victim
// check and is written from the fault state. The next address is taken only
// after a result is registered and the state is idle again, so a new address
// is not taken while the last one is still in flight.
// The output register holds a result while out_stall is high; the next
// address is still taken, and its lookup waits only if the register is full.
// Synchronous reset empties the TLB, marks every page not present and
// restarts frame allocation at frame zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tlb_page_table_translator import tlbpt_pkg::*; #(
  parameter int FRAME_COUNT = 128,
  parameter int PAGE_COUNT  = 256,
  parameter int TLB_DEPTH   = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [ADDR_W-1:0]      logical_address,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [PA_W-1:0]        physical_address,
  output logic [FRAME_OUT_W-1:0] frame_number,
  output logic [1:0]             outcome,
  output logic                   evicted_valid,
  output logic [PAGE_OUT_W-1:0]  evicted_page
);

  localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int FW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

  state_t state, state_next;

  logic [PW-1:0]       page_mod_tab [PAGE_TAB_N];
  logic [PW-1:0]       in_page;
  logic [PW-1:0]       page;
  logic [OFFSET_W-1:0] offset;
  logic [FW-1:0]       next_frame;
  logic                memory_full;

  logic [PW-1:0] pt_rd_addr_a;
  logic [FW-1:0] pt_frame_a;
  logic          pt_present_a;
  logic [FW-1:0] pt_frame_b;
  logic          pt_present_b;
  logic [PW-1:0] victim;
  logic          evict;

  logic          tlb_hit;
  logic [FW-1:0] tlb_frame;
  tlb_cmd_t      tlb_cmd;
  logic [FW-1:0] upd_frame;

  logic          out_free;
  logic          accept;
  logic          finish;
  logic          fault_done;
  logic [FW-1:0] res_frame;
  outcome_t      res_outcome;
  outcome_t      outcome_reg;

  // Page reduction modulo PAGE_COUNT as a constant table.
  for (genvar i = 0; i < PAGE_TAB_N; i++) begin : g_mod
    assign page_mod_tab[i] = PW'(i % PAGE_COUNT);
  end

  assign in_page      = page_mod_tab[logical_address[ADDR_W-1:OFFSET_W]];
  assign pt_rd_addr_a = (state == ST_IDLE) ? in_page : page;
  assign out_free     = !out_valid || !out_stall;
  assign accept       = in_valid && !in_stall;
  assign evict        = memory_full && pt_present_b && (pt_frame_b == next_frame);

  tlbpt_page_table #(
    .PAGE_COUNT  (PAGE_COUNT),
    .FRAME_COUNT (FRAME_COUNT)
  ) u_page_table (
    .clk          (clk),
    .rst          (rst),
    .rd_addr_a    (pt_rd_addr_a),
    .rd_addr_b    (victim),
    .rd_frame_a   (pt_frame_a),
    .rd_present_a (pt_present_a),
    .rd_frame_b   (pt_frame_b),
    .rd_present_b (pt_present_b),
    .wr_en        (fault_done),
    .wr_addr      (page),
    .wr_frame     (next_frame),
    .clr_en       (fault_done && evict),
    .clr_addr     (victim)
  );

  tlbpt_frame_owner #(
    .PAGE_COUNT  (PAGE_COUNT),
    .FRAME_COUNT (FRAME_COUNT)
  ) u_frame_owner (
    .clk     (clk),
    .rd_addr (next_frame),
    .rd_data (victim),
    .wr_en   (fault_done),
    .wr_addr (next_frame),
    .wr_data (page)
  );

  tlbpt_tlb #(
    .TLB_DEPTH   (TLB_DEPTH),
    .PAGE_COUNT  (PAGE_COUNT),
    .FRAME_COUNT (FRAME_COUNT)
  ) u_tlb (
    .clk         (clk),
    .rst         (rst),
    .lookup_page (page),
    .hit         (tlb_hit),
    .hit_frame   (tlb_frame),
    .cmd         (tlb_cmd),
    .upd_page    (page),
    .upd_frame   (upd_frame)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_stall       = 1'b1;
    finish         = 1'b0;
    fault_done     = 1'b0;
    tlb_cmd.insert = 1'b0;
    tlb_cmd.drop   = 1'b0;
    upd_frame      = pt_frame_a;
    res_frame      = tlb_frame;
    res_outcome    = OUT_TLB_HIT;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (tlb_hit) begin
          res_frame   = tlb_frame;
          res_outcome = OUT_TLB_HIT;
          if (out_free) begin
            finish     = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (pt_present_a) begin
          res_frame   = pt_frame_a;
          res_outcome = OUT_PT_HIT;
          if (out_free) begin
            finish         = 1'b1;
            tlb_cmd.insert = 1'b1;
            state_next     = ST_IDLE;
          end
        end else begin
          // The victim's page table entry is read on this edge.
          state_next = ST_FAULT;
        end
      end
      ST_FAULT: begin
        res_frame   = next_frame;
        res_outcome = OUT_FAULT;
        upd_frame   = next_frame;
        if (out_free) begin
          finish         = 1'b1;
          fault_done     = 1'b1;
          tlb_cmd.insert = 1'b1;
          tlb_cmd.drop   = memory_full;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page   <= in_page;
      offset <= logical_address[OFFSET_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_frame  <= '0;
      memory_full <= 1'b0;
    end else if (fault_done) begin
      if (next_frame == FW'(FRAME_COUNT - 1)) begin
        next_frame  <= '0;
        memory_full <= 1'b1;
      end else begin
        next_frame <= next_frame + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      frame_number     <= FRAME_OUT_W'(res_frame);
      physical_address <= {FRAME_OUT_W'(res_frame), offset};
      outcome_reg      <= res_outcome;
      evicted_valid    <= fault_done && evict;
      evicted_page     <= (fault_done && evict) ? PAGE_OUT_W'(victim) : '0;
    end
  end

  assign outcome = outcome_reg;

endmodule
